// ===== hdl/record_control_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the recorder control sequencer
// Checks are sampled on clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECORD_CONTROL_SEQUENCER_ASSERT_SVH
`define RECORD_CONTROL_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Types and constants shared by the recorder control sequencer modules.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int ELAPSED_W = 23;

    typedef enum logic [2:0] {
        ST_STOPPED    = 3'd0,
        ST_ARMED      = 3'd1,
        ST_RECORDING  = 3'd2,
        ST_PAUSED     = 3'd3,
        ST_FINALIZING = 3'd4,
        ST_FINISHED   = 3'd5,
        ST_ERROR      = 3'd6,
        ST_CANCELLED  = 3'd7
    } run_state_t;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_FORMAT = 3'd1;
    localparam logic [2:0] ERR_PAUSE  = 3'd2;
    localparam logic [2:0] ERR_RESUME = 3'd3;
    localparam logic [2:0] ERR_SUB    = 3'd4;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_USER  = 2'd1;
    localparam logic [1:0] REASON_MOTOR = 2'd2;

    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_MODE   = 2'd1;
    localparam logic [1:0] CFG_IDLE   = 2'd2;

    localparam logic [1:0]  FORMAT_RESET = 2'd0;
    localparam logic [1:0]  MODE_RESET   = 2'd1;
    localparam logic [15:0] IDLE_RESET   = 16'd5000;

    localparam logic [2:0] FUNC_SERVICE = 3'd0;
    localparam logic [2:0] FUNC_START   = 3'd1;
    localparam logic [2:0] FUNC_TOGGLE  = 3'd2;
    localparam logic [2:0] FUNC_STOP    = 3'd3;
    localparam logic [2:0] FUNC_CANCEL  = 3'd4;
    localparam logic [2:0] FUNC_RESET   = 3'd5;

    localparam logic [2:0] STAT_OTHER      = 3'd0;
    localparam logic [2:0] STAT_RECORDING  = 3'd1;
    localparam logic [2:0] STAT_PAUSED     = 3'd2;
    localparam logic [2:0] STAT_FINALIZING = 3'd3;
    localparam logic [2:0] STAT_FINISHED   = 3'd4;
    localparam logic [2:0] STAT_ERROR      = 3'd5;

    localparam logic [1:0] MODE_MANUAL   = 2'd0;
    localparam logic [1:0] MODE_MOTOR    = 2'd1;
    localparam logic [1:0] MODE_AUTO     = 2'd2;
    localparam logic [1:0] MODE_UNLISTED = 2'd3;

    localparam logic [1:0] FMT_WAV     = 2'd0;
    localparam logic [1:0] FMT_LEP     = 2'd1;
    localparam logic [1:0] FMT_L16     = 2'd2;
    localparam logic [1:0] FMT_INVALID = 2'd3;

    localparam logic [6:0] SC_START   = 7'h01;
    localparam logic [6:0] SC_PREVIEW = 7'h02;
    localparam logic [6:0] SC_PAUSE   = 7'h04;
    localparam logic [6:0] SC_RESUME  = 7'h08;
    localparam logic [6:0] SC_STOP    = 7'h10;
    localparam logic [6:0] SC_CANCEL  = 7'h20;
    localparam logic [6:0] SC_SERVICE = 7'h40;

    localparam logic [2:0] MC_WATCH = 3'h1;
    localparam logic [2:0] MC_ARM   = 3'h2;
    localparam logic [2:0] MC_STOP  = 3'h4;

    typedef struct packed {
        logic [1:0]  capture_format;
        logic [1:0]  ctrl_mode;
        logic [15:0] idle_stop_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  func;
        logic        motor_on;
        logic        auto_trigger;
        logic [15:0] edge_total;
        logic [31:0] now_ms;
        logic        sub_ok;
        logic [2:0]  sub_status;
    } item_t;

    typedef struct packed {
        run_state_t  run_state;
        logic        capture_active;
        logic        motor_paused;
        logic        user_paused;
        logic [31:0] active_start;
        logic [31:0] pause_start;
        logic        pause_valid;
        logic [31:0] paused_total;
        logic        removed;
        logic [15:0] last_edge;
        logic [31:0] last_activity;
        logic [2:0]  error_code;
        logic        sense;
    } state_t;

    localparam state_t STATE_RESET = '{
        run_state:      ST_STOPPED,
        capture_active: 1'b0,
        motor_paused:   1'b0,
        user_paused:    1'b0,
        active_start:   32'd0,
        pause_start:    32'd0,
        pause_valid:    1'b0,
        paused_total:   32'd0,
        removed:        1'b0,
        last_edge:      16'd0,
        last_activity:  32'd0,
        error_code:     ERR_NONE,
        sense:          1'b1
    };

    // Result of one step before the millisecond count is turned into seconds.
    typedef struct packed {
        run_state_t  run_state;
        logic        sense_level;
        logic [1:0]  pause_reason;
        logic [31:0] elapsed_ms;
        logic        file_removed;
        logic [2:0]  error_code;
        logic [6:0]  sub_commands;
        logic [2:0]  monitor_commands;
    } res_t;

    typedef struct packed {
        run_state_t           run_state;
        logic                 sense_level;
        logic [1:0]           pause_reason;
        logic [ELAPSED_W-1:0] elapsed_seconds;
        logic                 file_removed;
        logic [2:0]           error_code;
        logic [6:0]           sub_commands;
        logic [2:0]           monitor_commands;
    } result_t;

endpackage

// ===== hdl/record_control_sequencer.sv =====
// ----------------------------------------------------------------------------
// record_control_sequencer
// Recorder control sequencer: run state, pause tracking and command masks.
//
//   Channel  | Signals                         | Direction
//   ---------+---------------------------------+----------
//   item     | item_valid / item_ready + fields| in
//   result   | result_valid / result_ready     | out
//   cfg      | cfg_write, cfg_index, cfg_data  | in
//
// One beat is accepted per cycle while the pipeline is not stalled; its result
// passes through the input register, the step logic into a middle register,
// then the seconds conversion multiplier into the result register.
// rst_n clears the run state and the pipeline valids and loads the configuration reset values.
// A stalled result holds the pipeline; item_ready drops only when all stages
// are full and result_ready is low.
// ----------------------------------------------------------------------------
`include "record_control_sequencer_assert.svh"

module record_control_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  func,
    input  logic        motor_on,
    input  logic        auto_trigger,
    input  logic [15:0] edge_total,
    input  logic [31:0] now_ms,
    input  logic        sub_ok,
    input  logic [2:0]  sub_status,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  run_state,
    output logic        sense_level,
    output logic [1:0]  pause_reason,
    output logic [22:0] elapsed_seconds,
    output logic        file_removed,
    output logic [2:0]  error_code,
    output logic [6:0]  sub_commands,
    output logic [2:0]  monitor_commands
);
    import rcs_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    res_t    step_res;
    res_t    mid_res_reg;
    logic    mid_valid_reg;
    logic    mid_ready;
    logic    out_ready;
    logic    in_adv;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capture_format <= FORMAT_RESET;
            cfg_reg.ctrl_mode      <= MODE_RESET;
            cfg_reg.idle_stop_ms   <= IDLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FORMAT: cfg_reg.capture_format <= cfg_data[1:0];
                CFG_MODE:   cfg_reg.ctrl_mode      <= cfg_data[1:0];
                CFG_IDLE:   cfg_reg.idle_stop_ms   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign mid_ready  = !mid_valid_reg || out_ready;
    assign in_adv     = in_valid_reg && mid_ready;
    assign item_ready = !in_valid_reg || mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (mid_ready)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (in_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg.func         <= func;
            in_item_reg.motor_on     <= motor_on;
            in_item_reg.auto_trigger <= auto_trigger;
            in_item_reg.edge_total   <= edge_total;
            in_item_reg.now_ms       <= now_ms;
            in_item_reg.sub_ok       <= sub_ok;
            in_item_reg.sub_status   <= sub_status;
        end
        if (in_adv)
        begin
            mid_res_reg <= step_res;
        end
    end

    rcs_step u_step (
        .cur_state  (state_reg),
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    rcs_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (mid_res_reg),
        .res_valid    (mid_valid_reg),
        .res_ready    (out_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    assign run_state        = result.run_state;
    assign sense_level      = result.sense_level;
    assign pause_reason     = result.pause_reason;
    assign elapsed_seconds  = result.elapsed_seconds;
    assign file_removed     = result.file_removed;
    assign error_code       = result.error_code;
    assign sub_commands     = result.sub_commands;
    assign monitor_commands = result.monitor_commands;

    `RCS_ASSERT_IMP(a_reason_paused,
        result_valid && pause_reason != REASON_NONE,
        run_state == ST_PAUSED, "pause reason outside paused state")
    `RCS_ASSERT_IMP(a_error_code,
        result_valid && run_state == ST_ERROR,
        error_code != ERR_NONE && sense_level, "error state without code or idle sense")
    `RCS_ASSERT_NXT(a_state_hold,
        !in_adv, $stable(state_reg), "run state changed without a beat")

endmodule

// ===== hdl/rcs_step.sv =====
// ----------------------------------------------------------------------------
// rcs_step
// Next-state and command logic for one beat of the recorder control sequencer.
// ----------------------------------------------------------------------------
module rcs_step (
    input  rcs_pkg::state_t cur_state,
    input  rcs_pkg::item_t  item,
    input  rcs_pkg::cfg_t   cfg,
    output rcs_pkg::state_t state_next,
    output rcs_pkg::res_t   res
);
    import rcs_pkg::*;

    typedef struct packed {
        state_t     st;
        logic [6:0] sub_cmd;
        logic [2:0] mon_cmd;
    } ctx_t;

    function automatic ctx_t fn_fail(ctx_t c, logic [2:0] code);
        ctx_t r;
        r = c;
        r.st.run_state    = ST_ERROR;
        r.st.motor_paused = 1'b0;
        r.st.user_paused  = 1'b0;
        r.st.sense        = 1'b1;
        r.st.error_code   = code;
        r.mon_cmd         = r.mon_cmd | MC_STOP;
        return r;
    endfunction

    function automatic ctx_t fn_clear_engine(ctx_t c);
        ctx_t r;
        r = c;
        r.st      = STATE_RESET;
        r.mon_cmd = r.mon_cmd | MC_STOP;
        return r;
    endfunction

    function automatic ctx_t fn_begin(ctx_t c, item_t it, cfg_t cf);
        ctx_t r;
        r = c;
        if (!c.st.capture_active)
        begin
            if (cf.capture_format == FMT_INVALID)
            begin
                r = fn_fail(c, ERR_FORMAT);
            end
            else
            begin
                r.sub_cmd = r.sub_cmd | SC_START;
                if (!it.sub_ok)
                begin
                    r = fn_fail(r, ERR_SUB);
                end
                else
                begin
                    r.st.capture_active = 1'b1;
                    r.st.run_state      = ST_RECORDING;
                    r.st.motor_paused   = 1'b0;
                    r.st.user_paused    = 1'b0;
                    r.st.active_start   = it.now_ms;
                    r.st.pause_start    = 32'd0;
                    r.st.pause_valid    = 1'b0;
                    r.st.paused_total   = 32'd0;
                    if (cf.ctrl_mode == MODE_AUTO)
                    begin
                        if (cf.capture_format == FMT_WAV)
                        begin
                            r.mon_cmd = r.mon_cmd | MC_WATCH;
                        end
                        r.st.last_edge     = it.edge_total;
                        r.st.last_activity = it.now_ms;
                    end
                    r.st.sense = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // A successful pause records who asked for it: the user or the motor line.
    function automatic ctx_t fn_pause(ctx_t c, item_t it, logic by_user);
        ctx_t r;
        r = c;
        if (c.st.capture_active && c.st.run_state == ST_RECORDING)
        begin
            r.sub_cmd = r.sub_cmd | SC_PAUSE;
            if (!it.sub_ok)
            begin
                r = fn_fail(r, ERR_PAUSE);
            end
            else
            begin
                r.st.pause_start  = it.now_ms;
                r.st.pause_valid  = 1'b1;
                r.st.run_state    = ST_PAUSED;
                r.st.user_paused  = by_user;
                r.st.motor_paused = !by_user;
            end
        end
        return r;
    endfunction

    function automatic ctx_t fn_resume(ctx_t c, item_t it, cfg_t cf);
        ctx_t r;
        r = c;
        if (c.st.capture_active && c.st.run_state == ST_PAUSED)
        begin
            r.sub_cmd = r.sub_cmd | SC_RESUME;
            if (!it.sub_ok)
            begin
                r = fn_fail(r, ERR_RESUME);
            end
            else
            begin
                if (c.st.pause_valid)
                begin
                    r.st.paused_total = c.st.paused_total + (it.now_ms - c.st.pause_start);
                    r.st.pause_start  = 32'd0;
                    r.st.pause_valid  = 1'b0;
                end
                r.st.run_state    = ST_RECORDING;
                r.st.motor_paused = 1'b0;
                r.st.user_paused  = 1'b0;
                if (cf.ctrl_mode == MODE_AUTO)
                begin
                    r.st.last_edge     = it.edge_total;
                    r.st.last_activity = it.now_ms;
                end
            end
        end
        return r;
    endfunction

    // In motor mode with the motor stopped, a user resume hands the pause over to the motor.
    function automatic ctx_t fn_resume_user(ctx_t c, item_t it, cfg_t cf);
        ctx_t r;
        r = c;
        r.st.user_paused = 1'b0;
        if (cf.ctrl_mode == MODE_MOTOR && !it.motor_on)
        begin
            r.st.motor_paused = 1'b1;
        end
        else
        begin
            r.st.motor_paused = 1'b0;
            r = fn_resume(r, it, cf);
        end
        return r;
    endfunction

    function automatic ctx_t fn_cancel(ctx_t c, cfg_t cf);
        ctx_t r;
        r = c;
        r.st.removed = c.st.capture_active;
        if (c.st.capture_active && cf.capture_format != FMT_INVALID)
        begin
            r.sub_cmd = r.sub_cmd | SC_CANCEL;
        end
        r.st.run_state      = ST_CANCELLED;
        r.st.capture_active = 1'b0;
        r.st.motor_paused   = 1'b0;
        r.st.user_paused    = 1'b0;
        r.st.sense          = 1'b1;
        r.mon_cmd           = r.mon_cmd | MC_STOP;
        return r;
    endfunction

    function automatic ctx_t fn_stop(ctx_t c, cfg_t cf);
        ctx_t r;
        r = c;
        if (c.st.run_state == ST_ARMED)
        begin
            r = fn_cancel(c, cf);
        end
        else if (c.st.run_state == ST_RECORDING || c.st.run_state == ST_PAUSED)
        begin
            r.sub_cmd         = r.sub_cmd | SC_STOP;
            r.st.run_state    = ST_FINALIZING;
            r.st.motor_paused = 1'b0;
            r.st.user_paused  = 1'b0;
            r.mon_cmd         = r.mon_cmd | MC_STOP;
        end
        return r;
    endfunction

    function automatic ctx_t fn_start(ctx_t c, item_t it, cfg_t cf);
        ctx_t r;
        r = fn_clear_engine(c);
        if (cf.ctrl_mode == MODE_MANUAL)
        begin
            r.st.sense = 1'b0;
            r = fn_begin(r, it, cf);
        end
        else
        begin
            r.sub_cmd = r.sub_cmd | SC_PREVIEW;
            if (!it.sub_ok)
            begin
                r = fn_fail(r, ERR_SUB);
            end
            else
            begin
                r.st.sense     = 1'b0;
                r.st.run_state = ST_ARMED;
                if (cf.ctrl_mode == MODE_AUTO)
                begin
                    r.mon_cmd = r.mon_cmd | MC_ARM;
                end
            end
        end
        return r;
    endfunction

    function automatic ctx_t fn_service(ctx_t c, item_t it, cfg_t cf);
        ctx_t        r;
        logic [31:0] idle_ms;
        r = c;
        idle_ms = 32'd0;
        if (c.st.run_state == ST_ARMED)
        begin
            if ((cf.ctrl_mode == MODE_MOTOR && it.motor_on) ||
                (cf.ctrl_mode == MODE_AUTO && it.auto_trigger))
            begin
                r = fn_begin(c, it, cf);
            end
        end
        else
        begin
            if (cf.ctrl_mode == MODE_MOTOR)
            begin
                if (c.st.run_state == ST_RECORDING && !it.motor_on)
                begin
                    r = fn_pause(c, it, 1'b0);
                end
                else if (c.st.run_state == ST_PAUSED && !c.st.user_paused)
                begin
                    if (!it.motor_on)
                    begin
                        r.st.motor_paused = 1'b1;
                    end
                    else if (c.st.motor_paused)
                    begin
                        r.st.motor_paused = 1'b0;
                        r = fn_resume(r, it, cf);
                    end
                end
            end
            if (cf.ctrl_mode == MODE_AUTO && r.st.run_state == ST_RECORDING)
            begin
                idle_ms = it.now_ms - r.st.last_activity;
                if (it.edge_total != r.st.last_edge)
                begin
                    r.st.last_edge     = it.edge_total;
                    r.st.last_activity = it.now_ms;
                end
                else if (idle_ms >= {16'd0, cf.idle_stop_ms})
                begin
                    r = fn_stop(r, cf);
                end
            end
            // The sub-engine is serviced only for a known capture format.
            if (cf.capture_format != FMT_INVALID)
            begin
                r.sub_cmd = r.sub_cmd | SC_SERVICE;
                unique case (it.sub_status)
                    STAT_FINALIZING:
                    begin
                        r.st.run_state = ST_FINALIZING;
                    end
                    STAT_FINISHED:
                    begin
                        r.st.run_state    = ST_FINISHED;
                        r.st.motor_paused = 1'b0;
                        r.st.user_paused  = 1'b0;
                        r.st.sense        = 1'b1;
                        r.mon_cmd         = r.mon_cmd | MC_STOP;
                    end
                    STAT_ERROR:
                    begin
                        r = fn_fail(r, ERR_SUB);
                    end
                    STAT_PAUSED:
                    begin
                        r.st.run_state = ST_PAUSED;
                    end
                    STAT_RECORDING:
                    begin
                        if (r.st.run_state != ST_FINALIZING)
                        begin
                            r.st.run_state    = ST_RECORDING;
                            r.st.motor_paused = 1'b0;
                            r.st.user_paused  = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        return r;
    endfunction

    ctx_t        c0;
    ctx_t        c;
    logic [31:0] end_ms;
    logic [31:0] base_ms;

    always_comb
    begin
        c0.st      = cur_state;
        c0.sub_cmd = 7'd0;
        c0.mon_cmd = 3'd0;
        c          = c0;
        unique case (item.func)
            FUNC_SERVICE:
            begin
                c = fn_service(c0, item, cfg);
            end
            FUNC_START:
            begin
                c = fn_start(c0, item, cfg);
            end
            FUNC_TOGGLE:
            begin
                if (cur_state.run_state == ST_ARMED)
                begin
                    c = fn_begin(c0, item, cfg);
                    if (c.st.capture_active && cfg.ctrl_mode == MODE_MOTOR &&
                        !item.motor_on)
                    begin
                        c = fn_pause(c, item, 1'b0);
                    end
                end
                else if (cur_state.run_state == ST_RECORDING)
                begin
                    c = fn_pause(c0, item, 1'b1);
                end
                else if (cur_state.run_state == ST_PAUSED)
                begin
                    c = fn_resume_user(c0, item, cfg);
                end
            end
            FUNC_STOP:
            begin
                c = fn_stop(c0, cfg);
            end
            FUNC_CANCEL:
            begin
                c = fn_cancel(c0, cfg);
            end
            FUNC_RESET:
            begin
                c = fn_clear_engine(c0);
            end
            default:
            begin
                c = c0;
            end
        endcase
    end

    // Elapsed time ends at the pause start while paused and is zero with no active capture or on underflow.
    always_comb
    begin
        end_ms  = (c.st.run_state == ST_PAUSED && c.st.pause_valid) ?
                  c.st.pause_start : item.now_ms;
        base_ms = c.st.active_start + c.st.paused_total;
        if (!c.st.capture_active || end_ms < base_ms)
        begin
            res.elapsed_ms = 32'd0;
        end
        else
        begin
            res.elapsed_ms = end_ms - base_ms;
        end

        res.pause_reason = REASON_NONE;
        if (c.st.run_state == ST_PAUSED)
        begin
            if (c.st.user_paused)
            begin
                res.pause_reason = REASON_USER;
            end
            else if (c.st.motor_paused)
            begin
                res.pause_reason = REASON_MOTOR;
            end
        end

        res.run_state        = c.st.run_state;
        res.sense_level      = c.st.sense;
        res.file_removed     = c.st.removed;
        res.error_code       = c.st.error_code;
        res.sub_commands     = c.sub_cmd;
        res.monitor_commands = c.mon_cmd;
    end

    assign state_next = c.st;

endmodule

// ===== hdl/rcs_out_stage.sv =====
// ----------------------------------------------------------------------------
// rcs_out_stage
// Result register; converts elapsed milliseconds to whole seconds on the way.
// ----------------------------------------------------------------------------
module rcs_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  rcs_pkg::res_t    res,
    input  logic             res_valid,
    output logic             res_ready,
    output rcs_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_ready
);
    import rcs_pkg::*;

    localparam int          MS_PER_SEC = 1000;
    localparam int          DIV_SHIFT  = 38;
    localparam int          PROD_W     = 61;
    // Rounded-up reciprocal; the quotient is exact for every 32-bit dividend.
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + MS_PER_SEC - 1) / MS_PER_SEC;

    logic [PROD_W-1:0] prod;
    logic              valid_reg;
    result_t           result_reg;
    result_t           result_next;

    assign prod = PROD_W'(res.elapsed_ms) * PROD_W'(DIV_RECIP);

    always_comb
    begin
        result_next.run_state        = res.run_state;
        result_next.sense_level      = res.sense_level;
        result_next.pause_reason     = res.pause_reason;
        result_next.elapsed_seconds  = prod[DIV_SHIFT +: ELAPSED_W];
        result_next.file_removed     = res.file_removed;
        result_next.error_code       = res.error_code;
        result_next.sub_commands     = res.sub_commands;
        result_next.monitor_commands = res.monitor_commands;
    end

    assign res_ready = !valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule
